// ----- src/stsc_pkg.sv -----
// Shared types, codes and lookup functions of the source token scanner.
package stsc_pkg;

  localparam int OffsetBits    = 24;
  localparam int KeywordMaxLen = 9;
  localparam int FieldBits     = 24;
  localparam int CountBits     = 16;
  localparam int KindBits      = 6;
  localparam int NumKeywords   = 17;
  localparam int KwTextLen     = 9;
  localparam int KwLenBits     = 5;

  localparam logic [CountBits-1:0] CountMax = '1;

  typedef enum logic [7:0] {
    MODE_IDLE   = 8'b0000_0001,
    MODE_IDENT  = 8'b0000_0010,
    MODE_NUMBER = 8'b0000_0100,
    MODE_STRING = 8'b0000_1000,
    MODE_SLASH  = 8'b0001_0000,
    MODE_LINE   = 8'b0010_0000,
    MODE_BLOCK  = 8'b0100_0000,
    MODE_OP     = 8'b1000_0000
  } mode_e;

  localparam logic [KindBits-1:0] KIND_END     = 6'd0;
  localparam logic [KindBits-1:0] KIND_IDENT   = 6'd1;
  localparam logic [KindBits-1:0] KIND_NUMBER  = 6'd2;
  localparam logic [KindBits-1:0] KIND_STRING  = 6'd3;
  localparam logic [KindBits-1:0] KIND_KW0     = 6'd4;
  localparam logic [KindBits-1:0] KIND_LBRACE  = 6'd21;
  localparam logic [KindBits-1:0] KIND_RBRACE  = 6'd22;
  localparam logic [KindBits-1:0] KIND_LPAREN  = 6'd23;
  localparam logic [KindBits-1:0] KIND_RPAREN  = 6'd24;
  localparam logic [KindBits-1:0] KIND_SEMI    = 6'd25;
  localparam logic [KindBits-1:0] KIND_COMMA   = 6'd26;
  localparam logic [KindBits-1:0] KIND_DOT     = 6'd27;
  localparam logic [KindBits-1:0] KIND_STAR    = 6'd28;
  localparam logic [KindBits-1:0] KIND_AMP     = 6'd29;
  localparam logic [KindBits-1:0] KIND_PLUS    = 6'd30;
  localparam logic [KindBits-1:0] KIND_TILDE   = 6'd31;
  localparam logic [KindBits-1:0] KIND_LT      = 6'd32;
  localparam logic [KindBits-1:0] KIND_GT      = 6'd34;
  localparam logic [KindBits-1:0] KIND_ASSIGN  = 6'd36;
  localparam logic [KindBits-1:0] KIND_BANG    = 6'd38;
  localparam logic [KindBits-1:0] KIND_COLON   = 6'd40;
  localparam logic [KindBits-1:0] KIND_MINUS   = 6'd42;
  localparam logic [KindBits-1:0] KIND_UNKNOWN = 6'd44;

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_UNDER = 8'h5F;

  typedef struct packed {
    logic [7:0] source_char;
    logic       end_of_source;
  } in_item_t;

  typedef struct packed {
    logic [KindBits-1:0]  token_kind;
    logic [FieldBits-1:0] start_offset;
    logic [FieldBits-1:0] token_length;
    logic [CountBits-1:0] line;
    logic [CountBits-1:0] column;
    logic                 unterminated;
    logic                 last;
  } out_item_t;

  typedef struct packed {
    logic first;
    logic second;
  } push_t;

  // Keyword text right-aligned, first character most significant.
  localparam logic [8*KwTextLen-1:0] KW_TEXT [NumKeywords] = '{
    "class", "struct", "public", "private", "protected", "virtual",
    "override", "if", "else", "return", "new", "this", "const", "void",
    "enum", "auto", "final"
  };
  localparam int KW_LEN [NumKeywords] = '{5, 6, 6, 7, 9, 7, 8, 2, 4, 6, 3, 4, 5, 4, 4, 4, 5};

  function automatic logic is_letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_blank(logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
  endfunction

  function automatic logic [KindBits-1:0] single_kind(logic [7:0] c);
    logic [KindBits-1:0] k;
    case (c)
      "{":     k = KIND_LBRACE;
      "}":     k = KIND_RBRACE;
      "(":     k = KIND_LPAREN;
      ")":     k = KIND_RPAREN;
      ";":     k = KIND_SEMI;
      ",":     k = KIND_COMMA;
      ".":     k = KIND_DOT;
      "*":     k = KIND_STAR;
      "&":     k = KIND_AMP;
      "+":     k = KIND_PLUS;
      "~":     k = KIND_TILDE;
      default: k = KIND_UNKNOWN;
    endcase
    return k;
  endfunction

  function automatic logic is_pair_first(logic [7:0] c);
    return c == "<" || c == ">" || c == "=" || c == "!" || c == ":" || c == "-";
  endfunction

  function automatic logic [7:0] pair_second(logic [7:0] c);
    logic [7:0] s;
    case (c)
      ":":     s = ":";
      "-":     s = ">";
      default: s = "=";
    endcase
    return s;
  endfunction

  function automatic logic [KindBits-1:0] pair_kind(logic [7:0] c);
    logic [KindBits-1:0] k;
    case (c)
      "<":     k = KIND_LT;
      ">":     k = KIND_GT;
      "=":     k = KIND_ASSIGN;
      "!":     k = KIND_BANG;
      ":":     k = KIND_COLON;
      "-":     k = KIND_MINUS;
      default: k = KIND_UNKNOWN;
    endcase
    return k;
  endfunction

  function automatic logic [KindBits-1:0] name_kind(logic [KwTextLen-1:0][7:0] head,
                                                    logic [KwLenBits-1:0] len);
    logic [KindBits-1:0] k;
    logic                hit;
    k = KIND_IDENT;
    for (int i = 0; i < NumKeywords; i++) begin
      hit = (int'(len) == KW_LEN[i]);
      for (int j = 0; j < KwTextLen; j++) begin
        if (j < KW_LEN[i] && head[j] != KW_TEXT[i][(KW_LEN[i]-1-j)*8 +: 8]) begin
          hit = 1'b0;
        end
      end
      if (hit) begin
        k = KIND_KW0 + KindBits'(i);
      end
    end
    return k;
  endfunction

endpackage

// ----- src/stsc_if.sv -----
// Request channels of the source token scanner: input bytes and output tokens.
interface stsc_in_if;
  logic                valid;
  logic                ready;
  stsc_pkg::in_item_t  payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface stsc_out_if;
  logic                valid;
  logic                ready;
  stsc_pkg::out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ----- src/stsc_out_queue.sv -----
// Four-entry token queue that takes up to two tokens a cycle and hands out one.
module stsc_out_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  stsc_pkg::push_t     push_i,
  input  stsc_pkg::out_item_t first_i,
  input  stsc_pkg::out_item_t second_i,
  output logic                room_o,
  stsc_out_if.source          out_o
);

  stsc_pkg::out_item_t mem_q [4];
  logic [1:0] rd_q, rd_d, wr_q, wr_d;
  logic [2:0] count_q, count_d;
  logic       pop;
  logic [2:0] pushes;

  assign pop         = out_o.valid && out_o.ready;
  assign pushes      = 3'(push_i.first) + 3'(push_i.second);
  assign room_o      = count_q <= 3'd2;
  assign out_o.valid = count_q != 3'd0;
  assign out_o.payload = mem_q[rd_q];

  always_comb begin
    rd_d    = pop ? rd_q + 2'd1 : rd_q;
    wr_d    = wr_q + pushes[1:0];
    count_d = count_q + pushes - 3'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q    <= '0;
      wr_q    <= '0;
      count_q <= '0;
    end else begin
      rd_q    <= rd_d;
      wr_q    <= wr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.first) begin
      mem_q[wr_q] <= first_i;
    end
    if (push_i.second) begin
      mem_q[wr_q + 2'd1] <= second_i;
    end
  end

endmodule

// ----- src/source_token_scanner.sv -----
// Top level of the source token scanner: per-byte scan logic and token queue.
//
//  channel  dir  payload                                   handshake
//  in_i     in   source_char, end_of_source                valid/ready
//  out_o    out  token_kind, start_offset, token_length,   valid/ready
//                line, column, unterminated, last
//
// One byte is taken per cycle; its tokens (zero, one or two) are computed in the
// same cycle and enter a four-entry queue whose registered head drives out_o.
// in_i.ready drops while the queue holds more than two tokens; out_o drains one
// token per cycle while out_o.ready is high, so a stalled sink stops input.
// Reset (asynchronous, active low) empties the queue and returns the scanner to
// line 1, column 1, offset 0; the end of each source returns it there but keeps the queue.
module source_token_scanner #(
  parameter int OFFSET_BITS     = stsc_pkg::OffsetBits,
  parameter int KEYWORD_MAX_LEN = stsc_pkg::KeywordMaxLen
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  stsc_in_if.sink    in_i,
  stsc_out_if.source out_o
);

  localparam int OB = OFFSET_BITS;
  localparam int K  = KEYWORD_MAX_LEN;
  localparam int LB = $clog2(K + 2);
  localparam int FB = stsc_pkg::FieldBits;
  localparam int CB = stsc_pkg::CountBits;
  localparam int TB = stsc_pkg::KindBits;

  stsc_pkg::mode_e mode_q, mode_d, mode_a;
  logic [7:0]    held_q, held_d;
  logic [OB-1:0] pos_q, pos_n, pos_c, tstart_q, tstart_d;
  logic [CB-1:0] line_q, line_n, line_c, col_q, col_n, col_c;
  logic [7:0]    nbuf_q [K];
  logic [7:0]    nbuf_d [K];
  logic [LB-1:0] nlen_q, nlen_d;
  logic          esc_q, esc_d, star_q, star_d;

  logic [7:0] c;
  logic       eos, accept, room, used, skipped, b_go, consumed, word_c;
  logic       a_v, a_new, b_v, c_v;
  logic [TB-1:0] a_kind, b_kind, c_kind;
  logic          c_unterm;
  logic [OB-1:0] a_len, c_start, c_len;
  logic [stsc_pkg::KwTextLen-1:0][7:0] head_q, head_d;
  stsc_pkg::out_item_t it_a, it_b, it_c, first, second;
  stsc_pkg::push_t     push;

  assign c      = in_i.payload.source_char;
  assign eos    = in_i.payload.end_of_source;
  assign in_i.ready = room;
  assign accept = in_i.valid && room;
  assign word_c = stsc_pkg::is_letter(c) || stsc_pkg::is_digit(c) || c == stsc_pkg::CH_UNDER;

  function automatic logic [FB-1:0] fit(logic [OB-1:0] v);
    logic [OB+FB-1:0] w;
    w = {{FB{1'b0}}, v};
    return w[FB-1:0];
  endfunction

  always_comb begin
    for (int j = 0; j < stsc_pkg::KwTextLen; j++) begin
      head_q[j] = nbuf_q[j];
      head_d[j] = nbuf_d[j];
    end
  end

  // Counters after consuming the current byte.
  always_comb begin
    pos_n = pos_q + OB'(1);
    if (c == stsc_pkg::CH_LF) begin
      line_n = (line_q == stsc_pkg::CountMax) ? line_q : line_q + CB'(1);
      col_n  = CB'(1);
    end else begin
      line_n = line_q;
      col_n  = (col_q == stsc_pkg::CountMax) ? col_q : col_q + CB'(1);
    end
  end

  always_comb begin
    mode_a   = mode_q;
    held_d   = held_q;
    tstart_d = tstart_q;
    nbuf_d   = nbuf_q;
    nlen_d   = nlen_q;
    esc_d    = esc_q;
    star_d   = star_q;
    used     = 1'b0;
    skipped  = 1'b0;
    a_v      = 1'b0;
    a_new    = 1'b0;
    a_kind   = stsc_pkg::KIND_UNKNOWN;
    b_v      = 1'b0;
    b_kind   = stsc_pkg::KIND_UNKNOWN;

    // Finish or extend the token in progress.
    case (mode_q)
      stsc_pkg::MODE_IDENT: begin
        if (word_c) begin
          used = 1'b1;
          if (nlen_q < LB'(K)) begin
            nbuf_d[nlen_q[$clog2(K)-1:0]] = c;
          end
          if (nlen_q <= LB'(K)) begin
            nlen_d = nlen_q + LB'(1);
          end
        end else begin
          a_v    = 1'b1;
          a_kind = (nlen_q > LB'(K)) ? stsc_pkg::KIND_IDENT
                 : stsc_pkg::name_kind(head_q, stsc_pkg::KwLenBits'(nlen_q));
          mode_a = stsc_pkg::MODE_IDLE;
        end
      end
      stsc_pkg::MODE_NUMBER: begin
        if (stsc_pkg::is_digit(c)) begin
          used = 1'b1;
        end else begin
          a_v    = 1'b1;
          a_kind = stsc_pkg::KIND_NUMBER;
          mode_a = stsc_pkg::MODE_IDLE;
        end
      end
      stsc_pkg::MODE_STRING: begin
        used = 1'b1;
        if (esc_q) begin
          esc_d = 1'b0;
        end else if (c == stsc_pkg::CH_BSL) begin
          esc_d = 1'b1;
        end else if (c == stsc_pkg::CH_QUOTE) begin
          a_v    = 1'b1;
          a_new  = 1'b1;
          a_kind = stsc_pkg::KIND_STRING;
          mode_a = stsc_pkg::MODE_IDLE;
        end
      end
      stsc_pkg::MODE_SLASH: begin
        if (c == stsc_pkg::CH_SLASH) begin
          used    = 1'b1;
          skipped = 1'b1;
          mode_a  = stsc_pkg::MODE_LINE;
        end else if (c == stsc_pkg::CH_STAR) begin
          used    = 1'b1;
          skipped = 1'b1;
          star_d  = 1'b0;
          mode_a  = stsc_pkg::MODE_BLOCK;
        end else begin
          a_v    = 1'b1;
          a_kind = stsc_pkg::KIND_UNKNOWN;
          mode_a = stsc_pkg::MODE_IDLE;
        end
      end
      stsc_pkg::MODE_LINE: begin
        if (c == stsc_pkg::CH_LF) begin
          mode_a = stsc_pkg::MODE_IDLE;
        end else begin
          used    = 1'b1;
          skipped = 1'b1;
        end
      end
      stsc_pkg::MODE_BLOCK: begin
        used    = 1'b1;
        skipped = 1'b1;
        if (star_q && c == stsc_pkg::CH_SLASH) begin
          mode_a = stsc_pkg::MODE_IDLE;
        end else begin
          star_d = (c == stsc_pkg::CH_STAR);
        end
      end
      stsc_pkg::MODE_OP: begin
        a_v    = 1'b1;
        mode_a = stsc_pkg::MODE_IDLE;
        if (c == stsc_pkg::pair_second(held_q)) begin
          used   = 1'b1;
          a_new  = 1'b1;
          a_kind = stsc_pkg::pair_kind(held_q) + TB'(1);
        end else begin
          a_kind = stsc_pkg::pair_kind(held_q);
        end
      end
      default: mode_a = stsc_pkg::MODE_IDLE;
    endcase

    // Start a new token with this byte when it was not taken above.
    mode_d = mode_a;
    b_go   = !used && mode_a == stsc_pkg::MODE_IDLE;
    if (b_go) begin
      tstart_d = pos_q;
      if (stsc_pkg::is_blank(c)) begin
        skipped = 1'b1;
      end else if (stsc_pkg::is_letter(c) || c == stsc_pkg::CH_UNDER) begin
        nbuf_d[0] = c;
        nlen_d    = LB'(1);
        mode_d    = stsc_pkg::MODE_IDENT;
      end else if (stsc_pkg::is_digit(c)) begin
        mode_d = stsc_pkg::MODE_NUMBER;
      end else if (c == stsc_pkg::CH_QUOTE) begin
        esc_d  = 1'b0;
        mode_d = stsc_pkg::MODE_STRING;
      end else if (c == stsc_pkg::CH_SLASH) begin
        mode_d = stsc_pkg::MODE_SLASH;
      end else if (stsc_pkg::is_pair_first(c)) begin
        held_d = c;
        mode_d = stsc_pkg::MODE_OP;
      end else begin
        b_v    = 1'b1;
        b_kind = stsc_pkg::single_kind(c);
      end
    end

    consumed = used || b_go;
    pos_c    = consumed ? pos_n : pos_q;
    line_c   = consumed ? line_n : line_q;
    col_c    = consumed ? col_n : col_q;
    a_len    = (a_new ? pos_n : pos_q) - tstart_q;

    // Flush whatever is open at the end of the source.
    c_v      = 1'b0;
    c_kind   = stsc_pkg::KIND_END;
    c_unterm = 1'b0;
    if (eos) begin
      c_v = 1'b1;
      case (mode_d)
        stsc_pkg::MODE_IDENT: begin
          c_kind = (nlen_d > LB'(K)) ? stsc_pkg::KIND_IDENT
                 : stsc_pkg::name_kind(head_d, stsc_pkg::KwLenBits'(nlen_d));
        end
        stsc_pkg::MODE_NUMBER: c_kind = stsc_pkg::KIND_NUMBER;
        stsc_pkg::MODE_STRING: begin
          c_kind   = stsc_pkg::KIND_UNKNOWN;
          c_unterm = 1'b1;
        end
        stsc_pkg::MODE_SLASH: c_kind = stsc_pkg::KIND_UNKNOWN;
        stsc_pkg::MODE_OP:    c_kind = stsc_pkg::pair_kind(held_d);
        stsc_pkg::MODE_LINE,
        stsc_pkg::MODE_BLOCK: c_kind = stsc_pkg::KIND_END;
        default: c_v = skipped;
      endcase
    end
    c_start = (c_kind == stsc_pkg::KIND_END) ? pos_c : tstart_d;
    c_len   = (c_kind == stsc_pkg::KIND_END) ? '0 : pos_c - tstart_d;
  end

  always_comb begin
    it_a = '{token_kind: a_kind, start_offset: fit(tstart_q), token_length: fit(a_len),
             line: a_new ? line_n : line_q, column: a_new ? col_n : col_q,
             unterminated: 1'b0, last: 1'b0};
    it_b = '{token_kind: b_kind, start_offset: fit(pos_q), token_length: FB'(1),
             line: line_c, column: col_c, unterminated: 1'b0, last: 1'b0};
    it_c = '{token_kind: c_kind, start_offset: fit(c_start), token_length: fit(c_len),
             line: line_c, column: col_c, unterminated: c_unterm, last: 1'b0};
    first  = a_v ? it_a : (b_v ? it_b : it_c);
    second = b_v ? it_b : it_c;
    push.first  = accept && (a_v || b_v || c_v);
    push.second = accept && a_v && (b_v || c_v);
    // Mark the final token of the source.
    if (a_v && (b_v || c_v)) begin
      second.last = eos;
    end else begin
      first.last = eos;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= stsc_pkg::MODE_IDLE;
      held_q   <= '0;
      pos_q    <= '0;
      line_q   <= CB'(1);
      col_q    <= CB'(1);
      tstart_q <= '0;
      nlen_q   <= '0;
      esc_q    <= 1'b0;
      star_q   <= 1'b0;
    end else if (accept) begin
      if (eos) begin
        mode_q   <= stsc_pkg::MODE_IDLE;
        held_q   <= '0;
        pos_q    <= '0;
        line_q   <= CB'(1);
        col_q    <= CB'(1);
        tstart_q <= '0;
        nlen_q   <= '0;
        esc_q    <= 1'b0;
        star_q   <= 1'b0;
      end else begin
        mode_q   <= mode_d;
        held_q   <= held_d;
        pos_q    <= pos_c;
        line_q   <= line_c;
        col_q    <= col_c;
        tstart_q <= tstart_d;
        nlen_q   <= nlen_d;
        esc_q    <= esc_d;
        star_q   <= star_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      nbuf_q <= nbuf_d;
    end
  end

  stsc_out_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .first_i  (first),
    .second_i (second),
    .room_o   (room),
    .out_o    (out_o)
  );

endmodule

// ----- src/stsc_checker.sv -----
// Port-level assertions on the token output of the source token scanner.
module stsc_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input stsc_pkg::out_item_t out_payload_i
);

  // Hold a stalled token.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_payload_i))
    else $error("stalled token changed or dropped");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_payload_i.token_kind == stsc_pkg::KIND_END |->
      out_payload_i.token_length == '0 && out_payload_i.last)
    else $error("end token with length or not last");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_payload_i.unterminated |->
      out_payload_i.token_kind == stsc_pkg::KIND_UNKNOWN && out_payload_i.last)
    else $error("unterminated flag on wrong token");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_payload_i.line != '0 && out_payload_i.column != '0)
    else $error("line or column is zero");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_payload_i.token_kind != stsc_pkg::KIND_END |->
      out_payload_i.token_length != '0)
    else $error("token with zero length");

endmodule

bind source_token_scanner stsc_checker u_stsc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_payload_i (out_o.payload)
);

// ----- tb/sv/stsc_checker.sv -----
// Scoreboard of the source token scanner: predicts tokens per byte and compares them.
`timescale 1ns / 1ps

module stsc_scoreboard (
  input  logic  clk_i,
  input  logic  rst_ni,
  stsc_in_if    in_mon,
  stsc_out_if   out_mon,
  output int    errors_o,
  output int    pending_o
);
  import stsc_pkg::*;

  string keyword_list [NumKeywords] = '{
    "class", "struct", "public", "private", "protected", "virtual",
    "override", "if", "else", "return", "new", "this", "const", "void",
    "enum", "auto", "final"
  };

  out_item_t token_q[$];
  int        errors;

  mode_e                  mode;
  logic [7:0]             held;
  logic [OffsetBits-1:0]  pos;
  logic [CountBits-1:0]   line_cnt;
  logic [CountBits-1:0]   col_cnt;
  logic [OffsetBits-1:0]  tstart;
  logic [7:0]             name_buf [KeywordMaxLen];
  logic [3:0]             name_len;
  logic                   escape;
  logic                   star_seen;

  assign errors_o  = errors;
  assign pending_o = token_q.size();

  function automatic bit letter_ch(logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
  endfunction

  function automatic bit digit_ch(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic bit blank_ch(logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
  endfunction

  // Operators that may take a second character: kind of the single form.
  function automatic bit pair_of(logic [7:0] c, output logic [7:0] sec,
                                 output logic [KindBits-1:0] kind);
    sec  = "=";
    kind = KIND_UNKNOWN;
    case (c)
      "<": kind = KIND_LT;
      ">": kind = KIND_GT;
      "=": kind = KIND_ASSIGN;
      "!": kind = KIND_BANG;
      ":": begin kind = KIND_COLON; sec = ":"; end
      "-": begin kind = KIND_MINUS; sec = ">"; end
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  function automatic logic [KindBits-1:0] lone_kind(logic [7:0] c);
    string ops;
    ops = "{}();,.*&+~";
    for (int i = 0; i < ops.len(); i++) begin
      if (ops[i] == c) return KIND_LBRACE + KindBits'(i);
    end
    return KIND_UNKNOWN;
  endfunction

  function automatic logic [KindBits-1:0] word_kind();
    bit hit;
    if (name_len > KeywordMaxLen) return KIND_IDENT;
    for (int i = 0; i < NumKeywords; i++) begin
      hit = (keyword_list[i].len() == name_len);
      for (int j = 0; j < keyword_list[i].len() && hit; j++) begin
        if (keyword_list[i][j] != name_buf[j]) hit = 1'b0;
      end
      if (hit) return KIND_KW0 + KindBits'(i);
    end
    return KIND_IDENT;
  endfunction

  task automatic clear_scan();
    mode      = MODE_IDLE;
    held      = '0;
    pos       = '0;
    line_cnt  = CountBits'(1);
    col_cnt   = CountBits'(1);
    tstart    = '0;
    name_len  = '0;
    escape    = 1'b0;
    star_seen = 1'b0;
    for (int i = 0; i < KeywordMaxLen; i++) name_buf[i] = '0;
  endtask

  task automatic advance(logic [7:0] c);
    pos = pos + 1'b1;
    if (c == CH_LF) begin
      if (line_cnt != CountMax) line_cnt++;
      col_cnt = CountBits'(1);
    end else if (col_cnt != CountMax) begin
      col_cnt++;
    end
  endtask

  task automatic push_token(logic [KindBits-1:0] kind, logic [OffsetBits-1:0] start,
                            logic [OffsetBits-1:0] len, logic unterm, inout int n);
    out_item_t t;
    if (n >= 2) return;
    t.token_kind   = kind;
    t.start_offset = FieldBits'(start);
    t.token_length = FieldBits'(len);
    t.line         = line_cnt;
    t.column       = col_cnt;
    t.unterminated = unterm;
    t.last         = 1'b0;
    token_q.push_back(t);
    n++;
  endtask

  task automatic scan_byte(logic [7:0] c, logic eos);
    bit                  used;
    bit                  skipped;
    bit                  hit;
    int                  n;
    logic [7:0]          sec;
    logic [KindBits-1:0] pk;
    used    = 1'b0;
    skipped = 1'b0;
    n       = 0;
    case (mode)
      MODE_IDENT: begin
        if (letter_ch(c) || digit_ch(c) || c == CH_UNDER) begin
          if (name_len < KeywordMaxLen) name_buf[name_len] = c;
          if (name_len <= KeywordMaxLen) name_len++;
          advance(c);
          used = 1'b1;
        end else begin
          push_token(word_kind(), tstart, pos - tstart, 1'b0, n);
          mode = MODE_IDLE;
        end
      end
      MODE_NUMBER: begin
        if (digit_ch(c)) begin
          advance(c);
          used = 1'b1;
        end else begin
          push_token(KIND_NUMBER, tstart, pos - tstart, 1'b0, n);
          mode = MODE_IDLE;
        end
      end
      MODE_STRING: begin
        advance(c);
        used = 1'b1;
        if (escape) escape = 1'b0;
        else if (c == CH_BSL) escape = 1'b1;
        else if (c == CH_QUOTE) begin
          push_token(KIND_STRING, tstart, pos - tstart, 1'b0, n);
          mode = MODE_IDLE;
        end
      end
      MODE_SLASH: begin
        if (c == CH_SLASH) begin
          advance(c); used = 1'b1; skipped = 1'b1; mode = MODE_LINE;
        end else if (c == CH_STAR) begin
          advance(c); used = 1'b1; skipped = 1'b1; star_seen = 1'b0; mode = MODE_BLOCK;
        end else begin
          push_token(KIND_UNKNOWN, tstart, pos - tstart, 1'b0, n);
          mode = MODE_IDLE;
        end
      end
      MODE_LINE: begin
        if (c == CH_LF) mode = MODE_IDLE;
        else begin
          advance(c); used = 1'b1; skipped = 1'b1;
        end
      end
      MODE_BLOCK: begin
        advance(c); used = 1'b1; skipped = 1'b1;
        if (star_seen && c == CH_SLASH) mode = MODE_IDLE;
        else star_seen = (c == CH_STAR);
      end
      MODE_OP: begin
        hit = pair_of(held, sec, pk);
        if (hit && c == sec) begin
          advance(c);
          used = 1'b1;
          push_token(pk + 1'b1, tstart, pos - tstart, 1'b0, n);
        end else if (hit) begin
          push_token(pk, tstart, pos - tstart, 1'b0, n);
        end
        mode = MODE_IDLE;
      end
      default: mode = MODE_IDLE;
    endcase

    if (!used && mode == MODE_IDLE) begin
      tstart = pos;
      if (blank_ch(c)) begin
        advance(c); skipped = 1'b1;
      end else if (letter_ch(c) || c == CH_UNDER) begin
        name_buf[0] = c; name_len = 4'd1; advance(c); mode = MODE_IDENT;
      end else if (digit_ch(c)) begin
        advance(c); mode = MODE_NUMBER;
      end else if (c == CH_QUOTE) begin
        escape = 1'b0; advance(c); mode = MODE_STRING;
      end else if (c == CH_SLASH) begin
        advance(c); mode = MODE_SLASH;
      end else if (pair_of(c, sec, pk)) begin
        held = c; advance(c); mode = MODE_OP;
      end else begin
        advance(c);
        push_token(lone_kind(c), tstart, pos - tstart, 1'b0, n);
      end
    end

    if (eos) begin
      case (mode)
        MODE_IDENT:  push_token(word_kind(), tstart, pos - tstart, 1'b0, n);
        MODE_NUMBER: push_token(KIND_NUMBER, tstart, pos - tstart, 1'b0, n);
        MODE_STRING: push_token(KIND_UNKNOWN, tstart, pos - tstart, 1'b1, n);
        MODE_SLASH:  push_token(KIND_UNKNOWN, tstart, pos - tstart, 1'b0, n);
        MODE_OP: begin
          if (pair_of(held, sec, pk)) push_token(pk, tstart, pos - tstart, 1'b0, n);
          else push_token(KIND_UNKNOWN, tstart, pos - tstart, 1'b0, n);
        end
        MODE_LINE, MODE_BLOCK: push_token(KIND_END, pos, '0, 1'b0, n);
        default: if (skipped) push_token(KIND_END, pos, '0, 1'b0, n);
      endcase
      if (n > 0) token_q[$].last = 1'b1;
      clear_scan();
    end
  endtask

  task automatic report(string field, longint got, longint want);
    $display("mismatch at %0t: %s got %0d expected %0d", $time, field, got, want);
    errors++;
  endtask

  task automatic check_token(out_item_t got);
    out_item_t want;
    if (token_q.size() == 0) begin
      report("token_kind with none pending", got.token_kind, -1);
      return;
    end
    want = token_q.pop_front();
    if (got.token_kind != want.token_kind)
      report("token_kind", got.token_kind, want.token_kind);
    if (got.start_offset != want.start_offset)
      report("start_offset", got.start_offset, want.start_offset);
    if (got.token_length != want.token_length)
      report("token_length", got.token_length, want.token_length);
    if (got.line != want.line) report("line", got.line, want.line);
    if (got.column != want.column) report("column", got.column, want.column);
    if (got.unterminated != want.unterminated)
      report("unterminated", got.unterminated, want.unterminated);
    if (got.last != want.last) report("last", got.last, want.last);
  endtask

  initial begin
    errors = 0;
    clear_scan();
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_scan();
      token_q.delete();
    end else begin
      // Output first: a token predicted this edge cannot leave before the next.
      if (out_mon.valid && out_mon.ready) check_token(out_mon.payload);
      if (in_mon.valid && in_mon.ready)
        scan_byte(in_mon.payload.source_char, in_mon.payload.end_of_source);
    end
  end

endmodule

// ----- tb/sv/tb_source_token_scanner.sv -----
// Testbench top of the source token scanner: byte stimulus, token sink and verdict.
`timescale 1ns / 1ps

module tb_source_token_scanner;
  import stsc_pkg::*;

  localparam longint CycleLimit = 3000000;

  logic clk_i;
  logic rst_ni;
  int   errors;
  int   pending;
  int   items_sent;
  bit   quiet;
  longint cycles;

  stsc_in_if  in_ch ();
  stsc_out_if out_ch ();

  source_token_scanner dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch.sink),
    .out_o  (out_ch.source)
  );

  stsc_scoreboard scoreboard (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_mon    (in_ch),
    .out_mon   (out_ch),
    .errors_o  (errors),
    .pending_o (pending)
  );

  initial clk_i = 0;
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("source_token_scanner verification failed");
      $finish;
    end
  end

  logic [7:0] text_q[$];

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endtask

  task automatic send_byte(logic [7:0] c, logic eos);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.payload <= '{source_char: c, end_of_source: eos};
    do @(posedge clk_i); while (!in_ch.ready);
    items_sent++;
  endtask

  // Send the collected text as one source, marking its final byte.
  task automatic flush_source();
    for (int i = 0; i < text_q.size(); i++) send_byte(text_q[i], i == text_q.size() - 1);
    text_q.delete();
  endtask

  function automatic logic [7:0] word_ch(bit first);
    int r;
    r = $urandom_range(0, first ? 52 : 62);
    if (r < 26) return 8'(8'h61 + r);
    if (r < 52) return 8'(8'h41 + (r - 26));
    if (r == 52) return CH_UNDER;
    return 8'(8'h30 + (r - 53));
  endfunction

  task automatic add_fragment();
    string kw [17] = '{"class", "struct", "public", "private", "protected", "virtual",
                       "override", "if", "else", "return", "new", "this", "const",
                       "void", "enum", "auto", "final"};
    string ops [17] = '{"{", "}", "(", ")", ";", ",", ".", "*", "&", "+", "~",
                        "<=", ">=", "==", "!=", "::", "->"};
    string pf;
    string blanks;
    int len;
    pf = "<>=!:-";
    blanks = " \t\r\n";
    case ($urandom_range(0, 10))
      0: begin
        add_text(kw[$urandom_range(0, 16)]);
        if ($urandom_range(0, 3) == 0) text_q.push_back(word_ch(0));
      end
      1: begin
        len = $urandom_range(0, 3) == 0 ? $urandom_range(9, 14) : $urandom_range(1, 8);
        text_q.push_back(word_ch(1));
        repeat (len - 1) text_q.push_back(word_ch(0));
      end
      2: repeat ($urandom_range(1, 6)) text_q.push_back(8'(8'h30 + $urandom_range(0, 9)));
      3: begin
        text_q.push_back(CH_QUOTE);
        repeat ($urandom_range(0, 6)) begin
          if ($urandom_range(0, 3) == 0) begin
            text_q.push_back(CH_BSL);
            text_q.push_back($urandom_range(0, 1) ? CH_QUOTE : 8'($urandom_range(0, 255)));
          end else begin
            text_q.push_back(8'($urandom_range(32, 126)));
          end
        end
        text_q.push_back(CH_QUOTE);
      end
      4: begin
        add_text("//");
        repeat ($urandom_range(0, 6)) text_q.push_back($urandom_range(0, 1) ? "*" : "a");
        text_q.push_back(CH_LF);
      end
      5: begin
        add_text("/*");
        repeat ($urandom_range(0, 6))
          text_q.push_back($urandom_range(0, 2) == 0 ? CH_LF : ($urandom_range(0, 1) ? "*" : "x"));
        add_text("*/");
      end
      6: add_text(ops[$urandom_range(0, 16)]);
      7: text_q.push_back(pf[$urandom_range(0, 5)]);
      8: text_q.push_back(8'($urandom_range(0, 255)));
      9: text_q.push_back(CH_SLASH);
      default: repeat ($urandom_range(1, 3)) text_q.push_back(blanks[$urandom_range(0, 3)]);
    endcase
  endtask

  task automatic random_source();
    repeat ($urandom_range(1, 8)) begin
      add_fragment();
      if ($urandom_range(0, 1)) text_q.push_back(CH_SPACE);
    end
    case ($urandom_range(0, 5))
      0: text_q.push_back(CH_LF);
      1: add_text("// tail");
      2: add_text("/* open");
      3: add_text("\"open\\");
      default: ;
    endcase
    flush_source();
  endtask

  // Token sink: hold ready low for a drawn number of cycles after each request.
  initial begin
    int gap;
    out_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!(out_ch.valid && out_ch.ready));
      gap = quiet ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  end

  initial begin
    string directed [] = '{
      "class struct public private protected virtual override if else return new this x",
      "const void enum auto final _9 abcdefghij protectedx finalx",
      "{}();,.*&+~<<=>>==!=!:::-->@ ",
      "a/b / 12 345",
      "//c\n/* ** */ ",
      "/*/ x */",
      "\"a\\\"b\" \"open\\",
      "/*",
      "x//",
      "<"
    };
    cycles     = 0;
    items_sent = 0;
    quiet      = 0;
    rst_ni        = 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.payload <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) begin
      add_text(directed[i]);
      flush_source();
    end
    text_q.push_back(8'h00);
    text_q.push_back(8'hff);
    flush_source();

    while (items_sent < 1950) begin
      quiet = ($urandom_range(0, 3) == 0);
      random_source();
    end
    quiet = 0;
    in_ch.valid <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("source_token_scanner verification clean");
    end else begin
      $display("source_token_scanner verification failed");
    end
    $finish;
  end

endmodule
